// ===== rtl/lfuc_pkg.sv =====
package lfuc_pkg;

    localparam int LFUC_MAX_ENTRIES = 16;

    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CNT_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam logic [CNT_W-1:0] CNT_FIRST = 32'd1;

    localparam int S_TDATA_W = KEY_W + VAL_W;
    localparam int S_TUSER_W = 1;
    localparam int M_TDATA_W = VAL_W + KEY_W;
    localparam int M_TUSER_W = 2;

    localparam int TUSER_OP    = 0;
    localparam int TUSER_HIT   = 0;
    localparam int TUSER_EVICT = 1;

    typedef enum logic {
        OP_GET = 1'b0,
        OP_PUT = 1'b1
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] count;
    } entry_data_t;

    typedef struct packed {
        logic entry_we;
        logic rank_we;
    } store_wr_t;

endpackage

// ===== rtl/lfu_cache_with_lru_tiebreak.sv =====
// Channel   Direction  Handshake            Payload
// s_        in         s_tvalid/s_tready    s_tdata {write_value, lookup_key}, s_tuser {op}
// m_        out        m_tvalid/m_tready    m_tdata {evicted_key, read_value},
//                                           m_tuser {evicted, hit}
// cfg_      in         cfg_valid/cfg_ready  cfg_data {capacity_in_use}
//
// A hit or a put makes one key/victim scan and one recency pass, a get miss only the
// scan, and any item at capacity zero neither; each pass walks the entry memory
// through its single read port one entry a cycle.
// s_tready is high only between items. Reset clears the valid bits and occupancy.
// A result waits in the output register while m_tready is low; the block holds the
// last write-back until that register frees up.
module lfu_cache_with_lru_tiebreak #(
    parameter int MAX_ENTRIES = lfuc_pkg::LFUC_MAX_ENTRIES
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [lfuc_pkg::S_TDATA_W-1:0] s_tdata,  // lookup_key, write_value
    input  logic [lfuc_pkg::S_TUSER_W-1:0] s_tuser,  // op
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [lfuc_pkg::M_TDATA_W-1:0] m_tdata,  // read_value, evicted_key
    output logic [lfuc_pkg::M_TUSER_W-1:0] m_tuser,  // hit, evicted
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lfuc_pkg::CAP_W-1:0]     cfg_data  // capacity_in_use
);
    import lfuc_pkg::*;

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int SLOT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (SLOT_W > CAP_W) ? SLOT_W : CAP_W;
    localparam logic [SLOT_W-1:0] SLOTS   = SLOT_W'(MAX_ENTRIES);
    localparam logic [CMP_W-1:0]  SLOTS_X = CMP_W'(MAX_ENTRIES);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_SCAN   = 5'b00010,
        ST_DECIDE = 5'b00100,
        ST_UPDATE = 5'b01000,
        ST_COMMIT = 5'b10000
    } state_t;

    state_t                 state_reg, state_next;
    logic [CAP_W-1:0]       cap_reg, cap_next;
    logic [SLOT_W-1:0]      occ_reg, occ_next;
    logic [MAX_ENTRIES-1:0] valid_reg, valid_next;
    logic [SLOT_W-1:0]      cnt_reg, cnt_next;
    logic                   chk_vld_reg, chk_vld_next;
    logic                   m_tvalid_reg, m_tvalid_next;

    op_t                    op_reg, op_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [VAL_W-1:0]       wval_reg, wval_next;
    logic [IDX_W-1:0]       chk_idx_reg, chk_idx_next;
    logic                   found_reg, found_next;
    logic [IDX_W-1:0]       found_idx_reg, found_idx_next;
    logic [VAL_W-1:0]       found_val_reg, found_val_next;
    logic [CNT_W-1:0]       found_cnt_reg, found_cnt_next;
    logic [IDX_W-1:0]       found_rank_reg, found_rank_next;
    logic                   vic_vld_reg, vic_vld_next;
    logic [IDX_W-1:0]       vic_idx_reg, vic_idx_next;
    logic [CNT_W-1:0]       vic_cnt_reg, vic_cnt_next;
    logic [IDX_W-1:0]       vic_rank_reg, vic_rank_next;
    logic [KEY_W-1:0]       vic_key_reg, vic_key_next;
    logic                   free_vld_reg, free_vld_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [IDX_W-1:0]       tgt_idx_reg, tgt_idx_next;
    logic                   excl_en_reg, excl_en_next;
    logic [IDX_W-1:0]       excl_idx_reg, excl_idx_next;
    logic [SLOT_W-1:0]      lim_reg, lim_next;
    logic                   ins_reg, ins_next;
    logic                   evict_reg, evict_next;
    logic                   m_hit_reg, m_hit_next;
    logic                   m_evict_reg, m_evict_next;
    logic [VAL_W-1:0]       m_rval_reg, m_rval_next;
    logic [KEY_W-1:0]       m_ekey_reg, m_ekey_next;

    logic [CMP_W-1:0]       cap_x;
    logic [CMP_W-1:0]       cap_eff;
    logic                   cap_zero;
    logic                   full;
    logic                   issuing;
    logic                   pass_done;
    logic                   entry_v;
    logic                   key_match;
    logic                   better;
    logic                   out_free;
    logic [IDX_W-1:0]       rd_addr;
    entry_data_t            rd_data;
    logic [IDX_W-1:0]       rd_rank;
    store_wr_t              wr;
    logic [IDX_W-1:0]       wr_addr;
    entry_data_t            wr_data;
    logic [IDX_W-1:0]       wr_rank;

    lfuc_store #(
        .MAX_ENTRIES(MAX_ENTRIES)
    ) u_store (
        .aclk   (aclk),
        .rd_addr(rd_addr),
        .rd_data(rd_data),
        .rd_rank(rd_rank),
        .wr     (wr),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .wr_rank(wr_rank)
    );

    assign cap_x     = CMP_W'(cap_reg);
    assign cap_eff   = (cap_x > SLOTS_X) ? SLOTS_X : cap_x;
    assign cap_zero  = (cap_x == '0);
    assign full      = (CMP_W'(occ_reg) >= cap_eff);
    assign issuing   = (cnt_reg != SLOTS);
    assign pass_done = !issuing && !chk_vld_reg;
    assign rd_addr   = cnt_reg[IDX_W-1:0];
    assign entry_v   = valid_reg[chk_idx_reg];
    assign key_match = (rd_data.key == key_reg);
    assign better    = !vic_vld_reg || (rd_data.count < vic_cnt_reg) ||
                       ((rd_data.count == vic_cnt_reg) && (rd_rank > vic_rank_reg));
    assign out_free  = !m_tvalid_reg || m_tready;

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = {m_ekey_reg, m_rval_reg};
    assign m_tuser   = {m_evict_reg, m_hit_reg};

    always_comb begin
        state_next      = state_reg;
        cap_next        = cap_reg;
        occ_next        = occ_reg;
        valid_next      = valid_reg;
        cnt_next        = cnt_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        m_tvalid_next   = m_tvalid_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        wval_next       = wval_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        found_val_next  = found_val_reg;
        found_cnt_next  = found_cnt_reg;
        found_rank_next = found_rank_reg;
        vic_vld_next    = vic_vld_reg;
        vic_idx_next    = vic_idx_reg;
        vic_cnt_next    = vic_cnt_reg;
        vic_rank_next   = vic_rank_reg;
        vic_key_next    = vic_key_reg;
        free_vld_next   = free_vld_reg;
        free_idx_next   = free_idx_reg;
        tgt_idx_next    = tgt_idx_reg;
        excl_en_next    = excl_en_reg;
        excl_idx_next   = excl_idx_reg;
        lim_next        = lim_reg;
        ins_next        = ins_reg;
        evict_next      = evict_reg;
        m_hit_next      = m_hit_reg;
        m_evict_next    = m_evict_reg;
        m_rval_next     = m_rval_reg;
        m_ekey_next     = m_ekey_reg;
        wr              = '0;
        wr_addr         = tgt_idx_reg;
        wr_rank         = '0;
        wr_data.key     = key_reg;
        wr_data.value   = wval_reg;
        wr_data.count   = CNT_FIRST;

        if (cfg_valid) begin
            cap_next = cfg_data;
        end
        if (m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    op_next       = op_t'(s_tuser[TUSER_OP]);
                    key_next      = s_tdata[KEY_W-1:0];
                    wval_next     = s_tdata[KEY_W+VAL_W-1:KEY_W];
                    cnt_next      = '0;
                    found_next    = 1'b0;
                    vic_vld_next  = 1'b0;
                    free_vld_next = 1'b0;
                    ins_next      = 1'b0;
                    evict_next    = 1'b0;
                    state_next    = cap_zero ? ST_COMMIT : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (issuing) begin
                    cnt_next     = cnt_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_addr;
                end
                if (chk_vld_reg) begin
                    if (entry_v && key_match && !found_reg) begin
                        found_next      = 1'b1;
                        found_idx_next  = chk_idx_reg;
                        found_val_next  = rd_data.value;
                        found_cnt_next  = rd_data.count;
                        found_rank_next = rd_rank;
                    end
                    if (entry_v && better) begin
                        vic_vld_next  = 1'b1;
                        vic_idx_next  = chk_idx_reg;
                        vic_cnt_next  = rd_data.count;
                        vic_rank_next = rd_rank;
                        vic_key_next  = rd_data.key;
                    end
                    if (!entry_v && !free_vld_reg) begin
                        free_vld_next = 1'b1;
                        free_idx_next = chk_idx_reg;
                    end
                end
                if (pass_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                cnt_next = '0;
                if (found_reg) begin
                    excl_en_next  = 1'b1;
                    excl_idx_next = found_idx_reg;
                    lim_next      = SLOT_W'(found_rank_reg);
                    tgt_idx_next  = found_idx_reg;
                    state_next    = ST_UPDATE;
                end else if (op_reg == OP_GET) begin
                    state_next = ST_COMMIT;
                end else if (full) begin
                    evict_next    = 1'b1;
                    ins_next      = 1'b1;
                    excl_en_next  = 1'b1;
                    excl_idx_next = vic_idx_reg;
                    lim_next      = SLOT_W'(vic_rank_reg);
                    tgt_idx_next  = (free_vld_reg && (free_idx_reg < vic_idx_reg)) ?
                                    free_idx_reg : vic_idx_reg;
                    state_next    = ST_UPDATE;
                end else begin
                    ins_next     = 1'b1;
                    excl_en_next = 1'b0;
                    lim_next     = SLOTS;
                    tgt_idx_next = free_idx_reg;
                    state_next   = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (issuing) begin
                    cnt_next     = cnt_reg + 1'b1;
                    chk_vld_next = 1'b1;
                    chk_idx_next = rd_addr;
                end
                if (chk_vld_reg && entry_v && !(excl_en_reg && (chk_idx_reg == excl_idx_reg))
                    && (SLOT_W'(rd_rank) < lim_reg)) begin
                    wr.rank_we = 1'b1;
                    wr_addr    = chk_idx_reg;
                    wr_rank    = rd_rank + 1'b1;
                end
                if (pass_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_hit_next    = found_reg;
                    m_evict_next  = evict_reg;
                    m_rval_next   = (found_reg && (op_reg == OP_GET)) ? found_val_reg : '0;
                    m_ekey_next   = evict_reg ? vic_key_reg : '0;
                    if (found_reg) begin
                        wr.entry_we   = 1'b1;
                        wr_data.value = (op_reg == OP_GET) ? found_val_reg : wval_reg;
                        wr_data.count = (found_cnt_reg == CNT_MAX) ? found_cnt_reg :
                                        found_cnt_reg + 1'b1;
                    end
                    if (ins_reg) begin
                        wr.entry_we             = 1'b1;
                        valid_next[tgt_idx_reg] = 1'b1;
                        if (evict_reg && (tgt_idx_reg != vic_idx_reg)) begin
                            valid_next[vic_idx_reg] = 1'b0;
                        end
                        if (!evict_reg) begin
                            occ_next = occ_reg + 1'b1;
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CAP_RESET;
            occ_reg      <= '0;
            valid_reg    <= '0;
            cnt_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            occ_reg      <= occ_next;
            valid_reg    <= valid_next;
            cnt_reg      <= cnt_next;
            chk_vld_reg  <= chk_vld_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        wval_reg       <= wval_next;
        chk_idx_reg    <= chk_idx_next;
        found_reg      <= found_next;
        found_idx_reg  <= found_idx_next;
        found_val_reg  <= found_val_next;
        found_cnt_reg  <= found_cnt_next;
        found_rank_reg <= found_rank_next;
        vic_vld_reg    <= vic_vld_next;
        vic_idx_reg    <= vic_idx_next;
        vic_cnt_reg    <= vic_cnt_next;
        vic_rank_reg   <= vic_rank_next;
        vic_key_reg    <= vic_key_next;
        free_vld_reg   <= free_vld_next;
        free_idx_reg   <= free_idx_next;
        tgt_idx_reg    <= tgt_idx_next;
        excl_en_reg    <= excl_en_next;
        excl_idx_reg   <= excl_idx_next;
        lim_reg        <= lim_next;
        ins_reg        <= ins_next;
        evict_reg      <= evict_next;
        m_hit_reg      <= m_hit_next;
        m_evict_reg    <= m_evict_next;
        m_rval_reg     <= m_rval_next;
        m_ekey_reg     <= m_ekey_next;
    end

endmodule

// ===== rtl/lfuc_store.sv =====
module lfuc_store #(
    parameter int MAX_ENTRIES = lfuc_pkg::LFUC_MAX_ENTRIES,
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
    input  logic                  aclk,
    input  logic [IDX_W-1:0]      rd_addr,
    output lfuc_pkg::entry_data_t rd_data,
    output logic [IDX_W-1:0]      rd_rank,
    input  lfuc_pkg::store_wr_t   wr,
    input  logic [IDX_W-1:0]      wr_addr,
    input  lfuc_pkg::entry_data_t wr_data,
    input  logic [IDX_W-1:0]      wr_rank
);
    import lfuc_pkg::*;

    entry_data_t      data_mem [MAX_ENTRIES];
    logic [IDX_W-1:0] rank_mem [MAX_ENTRIES];

    entry_data_t      rd_data_reg;
    logic [IDX_W-1:0] rd_rank_reg;

    always_ff @(posedge aclk) begin
        if (wr.entry_we) begin
            data_mem[wr_addr] <= wr_data;
        end
        if (wr.entry_we || wr.rank_we) begin
            rank_mem[wr_addr] <= wr_rank;
        end
        rd_data_reg <= data_mem[rd_addr];
        rd_rank_reg <= rank_mem[rd_addr];
    end

    assign rd_data = rd_data_reg;
    assign rd_rank = rd_rank_reg;

endmodule

// ===== rtl/lfuc_checker.sv =====
module lfuc_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lfuc_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [lfuc_pkg::M_TUSER_W-1:0] m_tuser
);
    import lfuc_pkg::*;

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again right after an item");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("stalled result dropped");

    a_evict_only_on_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[TUSER_EVICT] |-> !m_tuser[TUSER_HIT])
        else $error("eviction reported on a hit");

    a_miss_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TUSER_HIT] |-> (m_tdata[VAL_W-1:0] == '0))
        else $error("read value nonzero on a miss");

    a_no_evict_key_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[TUSER_EVICT] |-> (m_tdata[VAL_W+KEY_W-1:VAL_W] == '0))
        else $error("evicted key nonzero without eviction");

endmodule

bind lfu_cache_with_lru_tiebreak lfuc_checker u_lfuc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
);
